// ----- sv/wfts_pkg.sv -----
package wfts_pkg;

   localparam int DEF_MAX_TASKS = 16;
   localparam int DEF_VRUNTIME_BITS = 48;

   localparam int ID_BITS = 8;
   localparam int LEVEL_BITS = 3;
   localparam int OUT_VR_BITS = 48;
   localparam int STATUS_BITS = 2;
   localparam int WEIGHT_BITS = 16;
   localparam int NUM_LEVELS = 5;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_INDEX_BITS = 3;

   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = 3'd4;

   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [REG_INDEX_BITS-1:0] REG_WEIGHT_NICE_0 = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_WEIGHT_NICE_1 = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_WEIGHT_NICE_2 = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_WEIGHT_NICE_3 = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_WEIGHT_NICE_4 = 3'd4;

   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_NICE_0 = 16'd6400;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_NICE_1 = 16'd8000;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_NICE_2 = 16'd10000;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_NICE_3 = 16'd12500;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT_NICE_4 = 16'd15625;

   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef weight_type [NUM_LEVELS-1:0] weight_set_type;

endpackage

// ----- sv/wfts_csr.sv -----
module wfts_csr
   import wfts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output weight_set_type           weights
);

   weight_set_type weights_ff, weights_in;
   logic [REG_INDEX_BITS-1:0] reg_index;
   logic write_en;

   assign reg_index = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign weights = weights_ff;

   always_comb begin
      weights_in = weights_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_WEIGHT_NICE_0: weights_in[0] = csr_pwdata[WEIGHT_BITS-1:0];
            REG_WEIGHT_NICE_1: weights_in[1] = csr_pwdata[WEIGHT_BITS-1:0];
            REG_WEIGHT_NICE_2: weights_in[2] = csr_pwdata[WEIGHT_BITS-1:0];
            REG_WEIGHT_NICE_3: weights_in[3] = csr_pwdata[WEIGHT_BITS-1:0];
            REG_WEIGHT_NICE_4: weights_in[4] = csr_pwdata[WEIGHT_BITS-1:0];
            default: weights_in = weights_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_WEIGHT_NICE_0: csr_prdata = CSR_DATA_BITS'(weights_ff[0]);
         REG_WEIGHT_NICE_1: csr_prdata = CSR_DATA_BITS'(weights_ff[1]);
         REG_WEIGHT_NICE_2: csr_prdata = CSR_DATA_BITS'(weights_ff[2]);
         REG_WEIGHT_NICE_3: csr_prdata = CSR_DATA_BITS'(weights_ff[3]);
         REG_WEIGHT_NICE_4: csr_prdata = CSR_DATA_BITS'(weights_ff[4]);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff[0] <= RESET_WEIGHT_NICE_0;
         weights_ff[1] <= RESET_WEIGHT_NICE_1;
         weights_ff[2] <= RESET_WEIGHT_NICE_2;
         weights_ff[3] <= RESET_WEIGHT_NICE_3;
         weights_ff[4] <= RESET_WEIGHT_NICE_4;
      end else begin
         weights_ff <= weights_in;
      end
   end

endmodule

// ----- sv/wfts_mem.sv -----
module wfts_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 59,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slots_ff[rd_addr];
   end

endmodule

// ----- sv/wfts_ctrl.sv -----
module wfts_ctrl
   import wfts_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int VRUNTIME_BITS = DEF_VRUNTIME_BITS,
   parameter int IDX_BITS = $clog2(MAX_TASKS),
   parameter int ENTRY_BITS = ID_BITS + LEVEL_BITS + VRUNTIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  weight_set_type         weights,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [ID_BITS-1:0]     req_new_task_id,
   input  logic [LEVEL_BITS-1:0]  req_new_task_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ID_BITS-1:0]     rsp_running_id,
   output logic                   rsp_running_valid,
   output logic [OUT_VR_BITS-1:0] rsp_running_vruntime,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic                   mem_wr_en,
   output logic [IDX_BITS-1:0]    mem_wr_addr,
   output logic [ENTRY_BITS-1:0]  mem_wr_data,
   output logic [IDX_BITS-1:0]    mem_rd_addr,
   input  logic [ENTRY_BITS-1:0]  mem_rd_data
);

   localparam int CNT_BITS = $clog2(MAX_TASKS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHARGE = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_PUT = 3'd3;
   localparam logic [2:0] ST_FRONT = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] pos_ff, pos_in;
   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [IDX_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ID_BITS-1:0] key_id_ff, key_id_in;
   logic [LEVEL_BITS-1:0] key_level_ff, key_level_in;
   logic [VRUNTIME_BITS-1:0] key_vr_ff, key_vr_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic rsp_run_valid_ff, rsp_run_valid_in;
   logic [OUT_VR_BITS-1:0] rsp_vr_ff, rsp_vr_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic [ID_BITS-1:0] rd_id;
   logic [LEVEL_BITS-1:0] rd_level;
   logic [VRUNTIME_BITS-1:0] rd_vr;
   logic [CNT_BITS:0] tail_sum;
   logic [IDX_BITS-1:0] tail;
   logic [VRUNTIME_BITS:0] charge_sum;
   logic [VRUNTIME_BITS-1:0] charged_vr;
   logic [OUT_VR_BITS+VRUNTIME_BITS-1:0] vr_wide;
   logic rsp_take;

   function automatic logic [IDX_BITS-1:0] ptr_dec(input logic [IDX_BITS-1:0] ptr);
      if (ptr == '0) begin
         return IDX_BITS'(MAX_TASKS - 1);
      end
      return ptr - 1'b1;
   endfunction

   function automatic logic [IDX_BITS-1:0] ptr_inc(input logic [IDX_BITS-1:0] ptr);
      if (ptr == IDX_BITS'(MAX_TASKS - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] lvl);
      if (lvl > LEVEL_TOP) begin
         return LEVEL_TOP;
      end
      return lvl;
   endfunction

   assign rd_id = mem_rd_data[ENTRY_BITS-1 -: ID_BITS];
   assign rd_level = mem_rd_data[VRUNTIME_BITS +: LEVEL_BITS];
   assign rd_vr = mem_rd_data[VRUNTIME_BITS-1:0];

   assign tail_sum = (CNT_BITS+1)'(head_ff) + (CNT_BITS+1)'(count_ff);
   assign tail = (tail_sum >= (CNT_BITS+1)'(MAX_TASKS)) ?
                 IDX_BITS'(tail_sum - (CNT_BITS+1)'(MAX_TASKS)) : IDX_BITS'(tail_sum);

   assign charge_sum = {1'b0, rd_vr} + (VRUNTIME_BITS+1)'(weights[clamp_level(rd_level)]);
   assign charged_vr = charge_sum[VRUNTIME_BITS] ? '1 : charge_sum[VRUNTIME_BITS-1:0];

   assign vr_wide = {{OUT_VR_BITS{1'b0}}, rd_vr};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_running_id = rsp_id_ff;
   assign rsp_running_valid = rsp_run_valid_ff;
   assign rsp_running_vruntime = rsp_vr_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      head_in = head_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      key_id_in = key_id_ff;
      key_level_in = key_level_ff;
      key_vr_in = key_vr_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_id_in = rsp_id_ff;
      rsp_run_valid_in = rsp_run_valid_ff;
      rsp_vr_in = rsp_vr_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = wr_ptr_ff;
      mem_wr_data = {key_id_ff, key_level_ff, key_vr_ff};
      mem_rd_addr = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = STATUS_OK;
               if (req_action == ACTION_ADD) begin
                  if (count_ff == CNT_BITS'(MAX_TASKS)) begin
                     status_in = STATUS_FULL;
                     state_in = ST_FRONT;
                  end else begin
                     key_id_in = req_new_task_id;
                     key_level_in = clamp_level(req_new_task_level);
                     key_vr_in = '0;
                     pos_in = count_ff;
                     wr_ptr_in = tail;
                     rd_ptr_in = ptr_dec(tail);
                     mem_rd_addr = ptr_dec(tail);
                     state_in = (count_ff == '0) ? ST_PUT : ST_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in = ST_FRONT;
                  end else begin
                     state_in = ST_CHARGE;
                  end
               end
            end
         end
         ST_CHARGE: begin
            key_id_in = rd_id;
            key_level_in = rd_level;
            key_vr_in = charged_vr;
            head_in = ptr_inc(head_ff);
            count_in = count_ff - 1'b1;
            pos_in = count_ff - 1'b1;
            wr_ptr_in = tail;
            rd_ptr_in = ptr_dec(tail);
            mem_rd_addr = ptr_dec(tail);
            state_in = (count_ff == CNT_BITS'(1)) ? ST_PUT : ST_SCAN;
         end
         ST_SCAN: begin
            mem_wr_en = 1'b1;
            if (rd_vr > key_vr_ff) begin
               mem_wr_data = mem_rd_data;
               wr_ptr_in = rd_ptr_ff;
               rd_ptr_in = ptr_dec(rd_ptr_ff);
               mem_rd_addr = ptr_dec(rd_ptr_ff);
               pos_in = pos_ff - 1'b1;
               if (pos_ff == CNT_BITS'(1)) begin
                  state_in = ST_PUT;
               end
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_FRONT;
            end
         end
         ST_PUT: begin
            mem_wr_en = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = ST_FRONT;
         end
         ST_FRONT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               if (count_ff != '0) begin
                  rsp_id_in = rd_id;
                  rsp_run_valid_in = 1'b1;
                  rsp_vr_in = vr_wide[OUT_VR_BITS-1:0];
               end else begin
                  rsp_id_in = '0;
                  rsp_run_valid_in = 1'b0;
                  rsp_vr_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      key_id_ff <= key_id_in;
      key_level_ff <= key_level_in;
      key_vr_ff <= key_vr_in;
      status_ff <= status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_run_valid_ff <= rsp_run_valid_in;
      rsp_vr_ff <= rsp_vr_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- sv/weighted_fair_task_scheduler_top.sv -----
// Keeps up to MAX_TASKS tasks in a table memory sorted by virtual runtime and reports the front
// (running) task once for every request transaction. An add places a task by an insertion
// scan, and a tick charges the front task and places it again. The scan moves each stored
// entry with a larger runtime than the task being placed, one entry a cycle through the
// single read port of the table memory. One request is worked on at a time, and the next is
// taken while the previous response waits. The user must write the weights through the APB
// port only while no transaction is in progress; the block itself does not enforce this. The
// table needs no clearing after reset, because the task count bounds every read.
module weighted_fair_task_scheduler_top
   import wfts_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int VRUNTIME_BITS = DEF_VRUNTIME_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [ID_BITS-1:0]       req_new_task_id,
   input  logic [LEVEL_BITS-1:0]    req_new_task_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ID_BITS-1:0]       rsp_running_id,
   output logic                     rsp_running_valid,
   output logic [OUT_VR_BITS-1:0]   rsp_running_vruntime,
   output logic [STATUS_BITS-1:0]   rsp_status,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int IDX_BITS = $clog2(MAX_TASKS);
   localparam int ENTRY_BITS = ID_BITS + LEVEL_BITS + VRUNTIME_BITS;

   weight_set_type weights;
   logic mem_wr_en;
   logic [IDX_BITS-1:0] mem_wr_addr;
   logic [ENTRY_BITS-1:0] mem_wr_data;
   logic [IDX_BITS-1:0] mem_rd_addr;
   logic [ENTRY_BITS-1:0] mem_rd_data;

   wfts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .weights     (weights)
   );

   wfts_mem #(
      .DEPTH     (MAX_TASKS),
      .WIDTH     (ENTRY_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   wfts_ctrl #(
      .MAX_TASKS     (MAX_TASKS),
      .VRUNTIME_BITS (VRUNTIME_BITS),
      .IDX_BITS      (IDX_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .weights              (weights),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_new_task_id      (req_new_task_id),
      .req_new_task_level   (req_new_task_level),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_running_id       (rsp_running_id),
      .rsp_running_valid    (rsp_running_valid),
      .rsp_running_vruntime (rsp_running_vruntime),
      .rsp_status           (rsp_status),
      .mem_wr_en            (mem_wr_en),
      .mem_wr_addr          (mem_wr_addr),
      .mem_wr_data          (mem_wr_data),
      .mem_rd_addr          (mem_rd_addr),
      .mem_rd_data          (mem_rd_data)
   );

endmodule

// ----- sv/wfts_checker.sv -----
module wfts_checker
   import wfts_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [ID_BITS-1:0]     rsp_running_id,
   input logic                   rsp_running_valid,
   input logic [OUT_VR_BITS-1:0] rsp_running_vruntime,
   input logic [STATUS_BITS-1:0] rsp_status
);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("A second request transaction was taken without a gap.");

   a_empty_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |-> rsp_running_id == '0 && rsp_running_vruntime == '0)
      else $error("An empty table reported a nonzero task.");

   a_full_has_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_running_valid)
      else $error("A dropped add reported an empty table.");

   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> !rsp_running_valid)
      else $error("A tick on an empty table reported a running task.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_running_id) &&
         $stable(rsp_running_valid) && $stable(rsp_running_vruntime) && $stable(rsp_status))
      else $error("A stalled response transaction changed.");

endmodule

bind weighted_fair_task_scheduler_top wfts_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_running_id       (rsp_running_id),
   .rsp_running_valid    (rsp_running_valid),
   .rsp_running_vruntime (rsp_running_vruntime),
   .rsp_status           (rsp_status)
);

// ----- test/weighted_fair_task_scheduler_top_test.sv -----
`timescale 1ns / 1ps

module weighted_fair_task_scheduler_top_test;
   import wfts_pkg::*;

   localparam int TABLE_DEPTH = DEF_MAX_TASKS;
   localparam int VR_BITS = DEF_VRUNTIME_BITS;
   localparam logic [VR_BITS-1:0] VR_CEILING = '1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;
   localparam logic [REG_INDEX_BITS-1:0] REG_UNUSED_FIRST = REG_WEIGHT_NICE_4 + 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_UNUSED_LAST = '1;

   typedef struct packed {
      logic                  action;
      logic [ID_BITS-1:0]    task_id;
      logic [LEVEL_BITS-1:0] level;
   } sched_request_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     running_id;
      logic                   running_valid;
      logic [OUT_VR_BITS-1:0] running_vruntime;
      logic [STATUS_BITS-1:0] status;
   } sched_report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACTION_ADD;
   logic [ID_BITS-1:0]       req_new_task_id = '0;
   logic [LEVEL_BITS-1:0]    req_new_task_level = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ID_BITS-1:0]       rsp_running_id;
   logic                     rsp_running_valid;
   logic [OUT_VR_BITS-1:0]   rsp_running_vruntime;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   weighted_fair_task_scheduler_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_new_task_id(req_new_task_id),
      .req_new_task_level(req_new_task_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_running_id(rsp_running_id),
      .rsp_running_valid(rsp_running_valid),
      .rsp_running_vruntime(rsp_running_vruntime),
      .rsp_status(rsp_status),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the task table and the per-level charges.
   weight_type            weight_table[NUM_LEVELS] = '{RESET_WEIGHT_NICE_0, RESET_WEIGHT_NICE_1,
      RESET_WEIGHT_NICE_2, RESET_WEIGHT_NICE_3, RESET_WEIGHT_NICE_4};
   logic [ID_BITS-1:0]    table_id[TABLE_DEPTH];
   logic [LEVEL_BITS-1:0] table_level[TABLE_DEPTH];
   logic [VR_BITS-1:0]    table_vr[TABLE_DEPTH];
   int                    table_count = 0;

   sched_request_type pending_requests[$];
   sched_report_type  expected_reports[$];
   sched_request_type on_wire;
   sched_report_type  observed;
   sched_report_type  wanted;

   bit idling_on = 1'b1;
   int send_gap = 0;
   int stall_left = 0;
   int cycle_count = 0;
   int error_count = 0;
   int checked_count = 0;
   int add_count = 0;
   int full_count = 0;
   int tick_count = 0;
   int empty_count = 0;
   int weight_writes = 0;

   task automatic place_task(input logic [ID_BITS-1:0] id, input logic [LEVEL_BITS-1:0] lvl,
                             input logic [VR_BITS-1:0] vr);
      int pos;
      pos = 0;
      while (pos < table_count && table_vr[pos] <= vr)
         pos++;
      for (int k = table_count; k > pos; k--) begin
         table_id[k] = table_id[k-1];
         table_level[k] = table_level[k-1];
         table_vr[k] = table_vr[k-1];
      end
      table_id[pos] = id;
      table_level[pos] = lvl;
      table_vr[pos] = vr;
      table_count++;
   endtask

   task automatic schedule_request(input sched_request_type req);
      sched_report_type      report;
      logic [ID_BITS-1:0]    id;
      logic [LEVEL_BITS-1:0] lvl;
      logic [VR_BITS:0]      charged;
      report.status = STATUS_OK;
      if (req.action == ACTION_ADD) begin
         add_count++;
         if (table_count >= TABLE_DEPTH) begin
            report.status = STATUS_FULL;
            full_count++;
         end else begin
            lvl = (req.level > LEVEL_TOP) ? LEVEL_TOP : req.level;
            place_task(req.task_id, lvl, '0);
         end
      end else begin
         tick_count++;
         if (table_count == 0) begin
            report.status = STATUS_EMPTY;
            empty_count++;
         end else begin
            id = table_id[0];
            lvl = table_level[0];
            charged = table_vr[0] + weight_table[lvl];
            for (int k = 1; k < table_count; k++) begin
               table_id[k-1] = table_id[k];
               table_level[k-1] = table_level[k];
               table_vr[k-1] = table_vr[k];
            end
            table_count--;
            place_task(id, lvl, charged[VR_BITS] ? VR_CEILING : charged[VR_BITS-1:0]);
         end
      end
      if (table_count > 0) begin
         report.running_id = table_id[0];
         report.running_valid = 1'b1;
         report.running_vruntime = table_vr[0][OUT_VR_BITS-1:0];
      end else begin
         report.running_id = '0;
         report.running_valid = 1'b0;
         report.running_vruntime = '0;
      end
      expected_reports.push_back(report);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            schedule_request(on_wire);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               on_wire = pending_requests.pop_front();
               req_action <= on_wire.action;
               req_new_task_id <= on_wire.task_id;
               req_new_task_level <= on_wire.level;
               req_valid <= 1'b1;
               if (idling_on && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed.running_id = rsp_running_id;
            observed.running_valid = rsp_running_valid;
            observed.running_vruntime = rsp_running_vruntime;
            observed.status = rsp_status;
            if (expected_reports.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("Unexpected result transaction: id %0d valid %0b vruntime %0d status %0d",
                           observed.running_id, observed.running_valid,
                           observed.running_vruntime, observed.status);
            end else begin
               wanted = expected_reports.pop_front();
               checked_count++;
               if (observed.running_id !== wanted.running_id ||
                   observed.running_valid !== wanted.running_valid ||
                   observed.running_vruntime !== wanted.running_vruntime ||
                   observed.status !== wanted.status) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("Mismatch on result %0d at cycle %0d:", checked_count, cycle_count);
                     $display("  expected id %0d valid %0b vruntime %0d status %0d",
                              wanted.running_id, wanted.running_valid,
                              wanted.running_vruntime, wanted.status);
                     $display("  actual   id %0d valid %0b vruntime %0d status %0d",
                              observed.running_id, observed.running_valid,
                              observed.running_vruntime, observed.status);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped by the cycle limit with %0d results outstanding",
                  expected_reports.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_weight(input logic [REG_INDEX_BITS-1:0] index, input weight_type value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'({index, 2'b00});
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index < NUM_LEVELS)
         weight_table[index] = value;
      weight_writes++;
   endtask

   task automatic program_weights(input weight_type w0, input weight_type w1, input weight_type w2,
                                  input weight_type w3, input weight_type w4);
      write_weight(REG_WEIGHT_NICE_0, w0);
      write_weight(REG_WEIGHT_NICE_1, w1);
      write_weight(REG_WEIGHT_NICE_2, w2);
      write_weight(REG_WEIGHT_NICE_3, w3);
      write_weight(REG_WEIGHT_NICE_4, w4);
   endtask

   task automatic push_request(input logic action, input logic [ID_BITS-1:0] id,
                               input logic [LEVEL_BITS-1:0] level);
      sched_request_type req;
      req.action = action;
      req.task_id = id;
      req.level = level;
      pending_requests.push_back(req);
   endtask

   task automatic push_random(input int count);
      for (int n = 0; n < count; n++)
         push_request(($urandom_range(0, 3) == 0) ? ACTION_ADD : ACTION_TICK,
                      ID_BITS'($urandom_range(0, 255)), LEVEL_BITS'($urandom_range(0, 7)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || send_gap != 0 ||
             expected_reports.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_request(ACTION_TICK, 8'h00, 3'd0);
      push_request(ACTION_ADD, 8'h00, 3'd0);
      push_request(ACTION_TICK, 8'hFF, 3'd7);
      push_request(ACTION_ADD, 8'hFF, 3'd4);
      push_request(ACTION_ADD, 8'hA5, 3'd7);
      push_request(ACTION_ADD, 8'h5A, 3'd5);
      push_request(ACTION_ADD, 8'h3C, 3'd6);
      push_request(ACTION_ADD, 8'h01, 3'd1);
      push_request(ACTION_ADD, 8'h02, 3'd2);
      push_request(ACTION_ADD, 8'h03, 3'd3);
      push_request(ACTION_TICK, 8'h00, 3'd0);
      push_request(ACTION_TICK, 8'h00, 3'd0);
      for (int n = 0; n < 8; n++)
         push_request(ACTION_ADD, ID_BITS'(8'h10 + n), LEVEL_BITS'(n % NUM_LEVELS));
      push_request(ACTION_ADD, 8'h80, 3'd2);
      push_request(ACTION_TICK, 8'h00, 3'd0);
      push_request(ACTION_TICK, 8'h00, 3'd0);
      wait_drained();

      program_weights('0, '0, '0, '0, '0);
      write_weight(REG_UNUSED_FIRST, weight_type'($urandom_range(0, 65535)));
      write_weight(REG_UNUSED_LAST, weight_type'($urandom_range(0, 65535)));
      push_random(100);
      wait_drained();

      idling_on = 1'b0;
      program_weights('1, '1, '1, '1, '1);
      push_random(100);
      wait_drained();

      idling_on = 1'b1;
      program_weights(weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)));
      push_random(150);
      wait_drained();

      program_weights('0, '1, weight_type'($urandom_range(0, 65535)), 16'd1,
                      weight_type'($urandom_range(0, 65535)));
      push_random(150);
      wait_drained();

      idling_on = 1'b0;
      program_weights(weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)),
                      weight_type'($urandom_range(0, 65535)));
      push_random(150);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d adds (%0d refused on a full table) and %0d ticks (%0d on empty).",
               add_count, full_count, tick_count, empty_count);
      $display("%0d weight register writes, %0d results checked, %0d mismatches.",
               weight_writes, checked_count, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- weighted_fair_task_scheduler_top.f -----
sv/wfts_pkg.sv
sv/wfts_csr.sv
sv/wfts_mem.sv
sv/wfts_ctrl.sv
sv/weighted_fair_task_scheduler_top.sv
sv/wfts_checker.sv
test/weighted_fair_task_scheduler_top_test.sv
